// ===== sv/tcf_pkg.sv =====
// tcf_pkg: shared constants, operation codes and the CORDIC arctangent table
// for the tilt complementary filter. No dependencies.
`default_nettype none
package tcf_pkg;

  localparam int CORDIC_STEPS = 18;
  localparam int TABLE_LEN    = 24;
  localparam int CORDIC_N     = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  localparam int ANGLE_W   = 25;
  localparam int ACC_W     = 56;
  localparam int MUL_A_W   = 34;
  localparam int MUL_B_W   = 18;
  localparam int CXY_W     = 34;
  localparam int RAD_W     = 60;
  localparam int SQRT_BITS = 30;
  localparam int CNT_W     = 5;

  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 25'sd11796480;
  localparam logic [16:0] WEIGHT_ONE   = 17'd65536;
  localparam logic [16:0] WEIGHT_RESET = 17'd1311;
  localparam logic [31:0] STEP_RESET   = 32'd187905;

  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_BITS - 1);
  localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(CORDIC_N - 1);

  // register indexes
  localparam logic REG_WEIGHT = 1'b0;
  localparam logic REG_STEP   = 1'b1;

  // datapath operations
  typedef logic [3:0] op_t;
  localparam op_t OP_NOP   = 4'd0;
  localparam op_t OP_LOAD  = 4'd1;
  localparam op_t OP_SQB   = 4'd2;
  localparam op_t OP_SQC   = 4'd3;
  localparam op_t OP_SQI   = 4'd4;
  localparam op_t OP_SQS   = 4'd5;
  localparam op_t OP_CI    = 4'd6;
  localparam op_t OP_CS    = 4'd7;
  localparam op_t OP_ANG   = 4'd8;
  localparam op_t OP_INC   = 4'd9;
  localparam op_t OP_PRED  = 4'd10;
  localparam op_t OP_MIX1  = 4'd11;
  localparam op_t OP_MIX2  = 4'd12;
  localparam op_t OP_STORE = 4'd13;
  localparam op_t OP_OUT   = 4'd14;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] idx;
    logic             axis;   // 0 pitch, 1 roll
  } cmd_t;

  // atan(2^-i) in Q16 degrees, rounded to nearest
  function automatic logic [21:0] atan_q16(input logic [CNT_W-1:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/tcf_ctrl.sv =====
// tcf_ctrl: sequencer for the tilt filter; issues datapath commands and owns
// the handshake state. Depends on tcf_pkg.
`default_nettype none
module tcf_ctrl (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  output tcf_pkg::cmd_t   cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQB   = 4'd1;
  localparam logic [3:0] S_SQC   = 4'd2;
  localparam logic [3:0] S_SQI   = 4'd3;
  localparam logic [3:0] S_SQS   = 4'd4;
  localparam logic [3:0] S_CI    = 4'd5;
  localparam logic [3:0] S_CS    = 4'd6;
  localparam logic [3:0] S_ANG   = 4'd7;
  localparam logic [3:0] S_INC   = 4'd8;
  localparam logic [3:0] S_PRED  = 4'd9;
  localparam logic [3:0] S_MIX1  = 4'd10;
  localparam logic [3:0] S_MIX2  = 4'd11;
  localparam logic [3:0] S_STORE = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0]                 state_r, state_nxt;
  logic [tcf_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       axis_r, axis_nxt;
  logic                       oval_r, oval_nxt;
  logic                       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = oval_r;
  assign out_free  = !oval_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    axis_nxt  = axis_r;
    oval_nxt  = oval_r && out_stall;
    cmd.op    = tcf_pkg::OP_NOP;
    cmd.idx   = cnt_r;
    cmd.axis  = axis_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = tcf_pkg::OP_LOAD;
          axis_nxt  = 1'b0;
          state_nxt = S_SQB;
        end
      end
      S_SQB: begin
        cmd.op = tcf_pkg::OP_SQB; state_nxt = S_SQC;
      end
      S_SQC: begin
        cmd.op = tcf_pkg::OP_SQC; state_nxt = S_SQI;
      end
      S_SQI: begin
        cmd.op = tcf_pkg::OP_SQI; cnt_nxt = tcf_pkg::SQRT_LAST; state_nxt = S_SQS;
      end
      S_SQS: begin
        cmd.op = tcf_pkg::OP_SQS;
        cnt_nxt = cnt_r - tcf_pkg::CNT_W'(1);
        if (cnt_r == '0) state_nxt = S_CI;
      end
      S_CI: begin
        cmd.op = tcf_pkg::OP_CI; cnt_nxt = '0; state_nxt = S_CS;
      end
      S_CS: begin
        cmd.op = tcf_pkg::OP_CS;
        cnt_nxt = cnt_r + tcf_pkg::CNT_W'(1);
        if (cnt_r == tcf_pkg::CORD_LAST) state_nxt = S_ANG;
      end
      S_ANG: begin
        cmd.op = tcf_pkg::OP_ANG; state_nxt = S_INC;
      end
      S_INC: begin
        cmd.op = tcf_pkg::OP_INC; state_nxt = S_PRED;
      end
      S_PRED: begin
        cmd.op = tcf_pkg::OP_PRED; state_nxt = S_MIX1;
      end
      S_MIX1: begin
        cmd.op = tcf_pkg::OP_MIX1; state_nxt = S_MIX2;
      end
      S_MIX2: begin
        cmd.op = tcf_pkg::OP_MIX2; state_nxt = S_STORE;
      end
      S_STORE: begin
        cmd.op = tcf_pkg::OP_STORE;
        if (axis_r) begin
          state_nxt = S_OUT;
        end else begin
          axis_nxt  = 1'b1;
          state_nxt = S_SQB;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.op    = tcf_pkg::OP_OUT;
          oval_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      axis_r  <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
      oval_r  <= oval_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/tcf_dp.sv =====
// tcf_dp: datapath of the tilt filter: shared multiplier/accumulator, bit-serial
// square root, iterative CORDIC and blend. Depends on tcf_pkg.
`default_nettype none
module tcf_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tcf_pkg::cmd_t        cmd,
  input  wire logic signed [15:0]   in_accel_x,
  input  wire logic signed [15:0]   in_accel_y,
  input  wire logic signed [15:0]   in_accel_z,
  input  wire logic signed [15:0]   in_rate_pitch_raw,
  input  wire logic signed [15:0]   in_rate_roll_raw,
  input  wire logic [16:0]          blend_weight,
  input  wire logic [31:0]          gyro_step,
  output logic signed [24:0]        out_pitch_deg,
  output logic signed [24:0]        out_roll_deg
);

  localparam int AW = tcf_pkg::ANGLE_W;

  logic signed [15:0] ax_r, ay_r, az_r, gp_r, gr_r;
  logic signed [tcf_pkg::ACC_W-1:0] acc_r;
  logic [tcf_pkg::RAD_W-1:0] rem_r, res_r;
  logic signed [tcf_pkg::CXY_W-1:0] x_r, y_r;
  logic signed [AW-1:0] z_r, ang_r, pitch_r, roll_r, opitch_r, oroll_r;
  logic signed [33:0] pred_r;

  logic signed [15:0] sel_a, sel_b, sel_c, sel_rate;
  logic signed [AW-1:0] sel_angle;
  logic signed [tcf_pkg::MUL_A_W-1:0] mul_a;
  logic signed [tcf_pkg::MUL_B_W-1:0] mul_b;
  logic signed [51:0] prod;
  logic [16:0] alpha, om_alpha;
  logic [tcf_pkg::RAD_W-1:0] one, trial;
  logic signed [tcf_pkg::CXY_W-1:0] xs, ys;
  logic signed [AW-1:0] tab;
  logic signed [39:0] mix;
  logic signed [AW-1:0] sat;

  assign sel_a     = cmd.axis ? ay_r : ax_r;
  assign sel_b     = cmd.axis ? ax_r : ay_r;
  assign sel_c     = az_r;
  assign sel_rate  = cmd.axis ? gr_r : gp_r;
  assign sel_angle = cmd.axis ? roll_r : pitch_r;

  assign alpha    = (blend_weight > tcf_pkg::WEIGHT_ONE) ? tcf_pkg::WEIGHT_ONE : blend_weight;
  assign om_alpha = tcf_pkg::WEIGHT_ONE - alpha;

  always_comb begin
    case (cmd.op)
      tcf_pkg::OP_SQB: begin
        mul_a = 34'(sel_b); mul_b = 18'(sel_b);
      end
      tcf_pkg::OP_SQC: begin
        mul_a = 34'(sel_c); mul_b = 18'(sel_c);
      end
      tcf_pkg::OP_INC: begin
        mul_a = $signed({2'b00, gyro_step}); mul_b = 18'(sel_rate);
      end
      tcf_pkg::OP_MIX1: begin
        mul_a = pred_r; mul_b = $signed({1'b0, om_alpha});
      end
      tcf_pkg::OP_MIX2: begin
        mul_a = 34'(ang_r); mul_b = $signed({1'b0, alpha});
      end
      default: begin
        mul_a = '0; mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // square root step: trial bit is 4^idx
  assign one   = tcf_pkg::RAD_W'(1) << {cmd.idx, 1'b0};
  assign trial = res_r + one;

  // CORDIC step
  assign xs  = x_r >>> cmd.idx;
  assign ys  = y_r >>> cmd.idx;
  assign tab = $signed({3'b000, tcf_pkg::atan_q16(cmd.idx)});

  assign mix = acc_r[55:16];
  always_comb begin
    if (mix > 40'(tcf_pkg::ANGLE_LIMIT))       sat = tcf_pkg::ANGLE_LIMIT;
    else if (mix < -40'(tcf_pkg::ANGLE_LIMIT)) sat = -tcf_pkg::ANGLE_LIMIT;
    else                                       sat = mix[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r <= '0;
      roll_r  <= '0;
    end else if (cmd.op == tcf_pkg::OP_STORE) begin
      if (cmd.axis) roll_r <= sat;
      else          pitch_r <= sat;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      tcf_pkg::OP_LOAD: begin
        ax_r <= in_accel_x; ay_r <= in_accel_y; az_r <= in_accel_z;
        gp_r <= in_rate_pitch_raw; gr_r <= in_rate_roll_raw;
      end
      tcf_pkg::OP_SQB:  acc_r <= 56'(prod);
      tcf_pkg::OP_SQC:  acc_r <= acc_r + 56'(prod);
      tcf_pkg::OP_SQI: begin
        rem_r <= {acc_r[31:0], 28'd0};
        res_r <= '0;
      end
      tcf_pkg::OP_SQS: begin
        if (rem_r >= trial) begin
          rem_r <= rem_r - trial;
          res_r <= (res_r >> 1) + one;
        end else begin
          res_r <= res_r >> 1;
        end
      end
      tcf_pkg::OP_CI: begin
        x_r <= $signed({3'b000, res_r[30:0]});
        y_r <= $signed({{4{sel_a[15]}}, sel_a, 14'd0});
        z_r <= '0;
      end
      tcf_pkg::OP_CS: begin
        if (!y_r[tcf_pkg::CXY_W-1]) begin
          x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + tab;
        end else begin
          x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - tab;
        end
      end
      tcf_pkg::OP_ANG:  ang_r <= (sel_a == '0) ? '0 : z_r;
      tcf_pkg::OP_INC:  acc_r <= 56'(prod) + 56'sd32768;
      tcf_pkg::OP_PRED: pred_r <= 34'(sel_angle) + 34'($signed(acc_r[47:16]));
      tcf_pkg::OP_MIX1: acc_r <= 56'(prod) + 56'sd32768;
      tcf_pkg::OP_MIX2: acc_r <= acc_r + 56'(prod);
      tcf_pkg::OP_OUT: begin
        opitch_r <= pitch_r; oroll_r <= roll_r;
      end
      default: ;
    endcase
  end

  assign out_pitch_deg = opitch_r;
  assign out_roll_deg  = oroll_r;

endmodule
`default_nettype wire

// ===== sv/tilt_complementary_filter.sv =====
// tilt_complementary_filter: top level; configuration registers and the
// controller/datapath pair. Depends on tcf_pkg, tcf_ctrl, tcf_dp.
//
// - Input channel (in_*): one IMU sample per transaction, raw accel x/y/z and
//   gyro rates for pitch and roll. Accepted when in_valid && !in_stall.
// - Result channel (out_*): one transaction per sample with the new pitch and
//   roll angles, signed Q9.16 degrees, saturated to +/-180.
// - APB port: blend weight at 0x0, gyro step at 0x4; pready is tied high.
//   Write only while the block is idle.
// - Sequence: each axis runs two square/accumulate passes, root setup, 30
//   square-root bit steps, CORDIC setup, CORDIC_N (18) vectoring steps,
//   then angle, gyro increment, prediction, two blend multiplies and the
//   store. The axes run one after the other on the shared datapath; a last
//   step then loads the output register.
// - One sample at a time: in_stall stays high from accept until the result
//   is loaded into the output register.
// - While out_stall holds a result, the next sample is computed and waits at
//   its end until the output register is taken.
// - Reset (rst_n low, synchronous) clears both angles, the handshake state
//   and loads the register defaults.
`default_nettype none
module tilt_complementary_filter (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_accel_x,
  input  wire logic signed [15:0] in_accel_y,
  input  wire logic signed [15:0] in_accel_z,
  input  wire logic signed [15:0] in_rate_pitch_raw,
  input  wire logic signed [15:0] in_rate_roll_raw,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [24:0]      out_pitch_deg,
  output logic signed [24:0]      out_roll_deg,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [16:0] weight_r;
  logic [31:0] step_r;
  logic        wr_en;
  tcf_pkg::cmd_t cmd;

  // register decode uses the word address bit only
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= tcf_pkg::WEIGHT_RESET;
      step_r   <= tcf_pkg::STEP_RESET;
    end else if (wr_en) begin
      if (paddr[2] == tcf_pkg::REG_WEIGHT) weight_r <= pwdata[16:0];
      else                                 step_r   <= pwdata;
    end
  end

  assign prdata = (paddr[2] == tcf_pkg::REG_WEIGHT) ? {15'd0, weight_r} : step_r;

  tcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  tcf_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_accel_x        (in_accel_x),
    .in_accel_y        (in_accel_y),
    .in_accel_z        (in_accel_z),
    .in_rate_pitch_raw (in_rate_pitch_raw),
    .in_rate_roll_raw  (in_rate_roll_raw),
    .blend_weight      (weight_r),
    .gyro_step         (step_r),
    .out_pitch_deg     (out_pitch_deg),
    .out_roll_deg      (out_roll_deg)
  );

endmodule
`default_nettype wire

// ===== sv/tcf_checker.sv =====
// tcf_checker: port-level assertions for tilt_complementary_filter, bound to
// the top level. Depends on tilt_complementary_filter.
`default_nettype none
module tcf_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [24:0] out_pitch_deg,
  input wire logic signed [24:0] out_roll_deg
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // one sample at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second sample accepted while busy");

  // angles stay inside +/-180 degrees
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_deg <= 25'sd11796480) && (out_pitch_deg >= -25'sd11796480)
      && (out_roll_deg <= 25'sd11796480) && (out_roll_deg >= -25'sd11796480))
    else $error("angle out of range");

  // reset empties the result channel
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind tilt_complementary_filter tcf_checker u_tcf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_pitch_deg (out_pitch_deg),
  .out_roll_deg  (out_roll_deg)
);
`default_nettype wire
